>>> hw/rtl/spjq_pkg.sv
`timescale 1ns / 1ps
package spjq_pkg;

    localparam int ID_W   = 16;
    localparam int PRI_W  = 8;
    localparam int DUR_W  = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic [PRI_W-1:0] priority_lvl;
        logic [ID_W-1:0]  id;
    } job_t;

    typedef struct packed {
        logic load;
        logic exec;
    } spjq_cmd_t;

endpackage

>>> hw/rtl/spjq_ctrl.sv
`timescale 1ns / 1ps
module spjq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output spjq_pkg::spjq_cmd_t cmd
);
    import spjq_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg, s_tready_next;
    logic   m_tvalid_reg, m_tvalid_next;

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd.load      = 1'b0;
        cmd.exec      = 1'b0;
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    cmd.exec      = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        s_tready_next = (state_next == S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s_tready_reg <= s_tready_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = s_tready_reg;
    assign m_tvalid = m_tvalid_reg;

endmodule

>>> hw/rtl/spjq_datapath.sv
`timescale 1ns / 1ps
module spjq_datapath #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spjq_pkg::spjq_cmd_t                 cmd,
    input  logic [spjq_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    output logic [spjq_pkg::OUT_DATA_W-1:0]     m_tdata,
    output logic [spjq_pkg::STAT_W-1:0]         m_tuser
);
    import spjq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    job_t              cell_reg [QUEUE_DEPTH];
    logic [CW-1:0]     count_reg, count_next;
    job_t              req_job_reg;
    logic              req_type_reg;
    job_t              out_job_reg;
    logic [STAT_W-1:0] out_stat_reg;
    logic [CW-1:0]     out_count_reg;

    logic [QUEUE_DEPTH-1:0] mark;
    logic                   do_insert, do_remove;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_job_reg  <= job_t'(s_tdata);
            req_type_reg <= s_tuser;
        end
    end

    // cells at or behind the insertion point
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            mark[i] = (CW'(i) >= count_reg) ||
                      (cell_reg[i].priority_lvl < req_job_reg.priority_lvl);
        end
    end

    assign do_insert = cmd.exec && (req_type_reg == REQ_INSERT) && (count_reg != DEPTH_C);
    assign do_remove = cmd.exec && (req_type_reg == REQ_REMOVE) && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_remove)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++)
    begin : g_cell
        logic prev_mark;
        job_t behind;
        if (g == 0)
        begin : g_head
            assign prev_mark = 1'b0;
        end
        else
        begin : g_body
            assign prev_mark = mark[g-1];
        end
        if (g == QUEUE_DEPTH - 1)
        begin : g_last
            assign behind = cell_reg[g];
        end
        else
        begin : g_mid
            assign behind = cell_reg[g+1];
        end

        always_ff @(posedge clk)
        begin
            if (do_insert)
            begin
                if (prev_mark)
                begin
                    cell_reg[g] <= cell_reg[(g == 0) ? 0 : g-1];
                end
                else if (mark[g])
                begin
                    cell_reg[g] <= req_job_reg;
                end
            end
            else if (do_remove)
            begin
                cell_reg[g] <= behind;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_count_reg <= count_next;
            out_job_reg   <= '0;
            if (req_type_reg == REQ_INSERT)
            begin
                out_stat_reg <= (count_reg == DEPTH_C) ? ST_FULL : ST_OK;
            end
            else if (count_reg == '0)
            begin
                out_stat_reg <= ST_EMPTY;
            end
            else
            begin
                out_stat_reg <= ST_OK;
                out_job_reg  <= cell_reg[0];
            end
        end
    end

    assign m_tdata = {3'b000, OCC_W'(out_count_reg), out_job_reg};
    assign m_tuser = out_stat_reg;

endmodule

>>> hw/rtl/stable_priority_job_queue.sv
`timescale 1ns / 1ps
// channel   | dir | tdata (low bit up)                           | tuser
// s_axis    | in  | job_id, job_priority, job_duration (56 b)    | req_type
// m_axis    | out | out_id, out_priority, out_duration,          | status
//           |     | occupancy, zero pad (64 b)                   |
// each request is first captured, then every cell compares its priority
// in parallel and shifts or loads at once
// a new request is taken while the previous result waits on m_axis
// an unfinished result stalls execution until m_tready frees the output register
// reset clears the job count; cell contents are only read below the count
module stable_priority_job_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,  // job_id, job_priority, job_duration
    input  logic        s_tuser,  // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,  // out_id, out_priority, out_duration, occupancy
    output logic [1:0]  m_tuser   // status
);
    import spjq_pkg::*;

    spjq_cmd_t cmd;

    spjq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    spjq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    a_exec_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> m_tvalid)
        else $error("executed request produced no result beat");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second request accepted while one is pending");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == ST_OK || m_tuser == ST_EMPTY || m_tuser == ST_FULL))
        else $error("bad status code");

    a_error_no_job: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_OK) |-> (m_tdata[55:0] == '0))
        else $error("error result carries job data");

endmodule
